@@ rtl/core/prag_pkg.sv @@
`timescale 1ns / 1ps

package prag_pkg;

	localparam int MAX_RANGES = 8;
	localparam int RANGE_W    = $clog2(MAX_RANGES);
	localparam int OFFSET_W   = 24;
	localparam int UB_W       = 8;
	localparam int UC_W       = 16;
	localparam int CNT_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [OFFSET_W-1:0]  offset_t;
	typedef logic [1:0]           mode_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam mode_t MODE_NEXT       = 2'd0;
	localparam mode_t MODE_REWIND_ONE = 2'd1;
	localparam mode_t MODE_REWIND_ALL = 2'd2;
	localparam mode_t MODE_EVEN_OUT   = 2'd3;

	localparam cfg_idx_t REG_UNIT_BYTES = 2'd0;
	localparam cfg_idx_t REG_UNIT_COUNT = 2'd1;

endpackage

@@ rtl/core/partitioned_range_address_generator_core.sv @@
`timescale 1ns / 1ps
// Channel   Handshake             Beat
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
// in        in_valid/in_stall     mode, range_index, range_count
// out       out_valid/out_stall   offset, valid_res
//
// Next runs a compare step, then an advance step that waits for the output slot.
// Rewind one and rewind all run an 8-step shift-add multiply, then the range writes.
// Even out runs an 8-step multiply, a 16-step restoring divide, an 8-step multiply, then n range writes.
// All offset, multiply and divide adds and subtracts share one 24-bit add/subtract unit; in_stall is high while busy.
// Reset clears every cursor and end, sets unit_bytes to 16 and unit_count to 0.
// A new beat is accepted while a result waits on a stalled output.
module partitioned_range_address_generator_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  prag_pkg::cfg_idx_t                 cfg_index,
	input  logic [prag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  prag_pkg::mode_t                    mode,
	input  logic [2:0]                         range_index,
	input  logic [prag_pkg::CNT_W-1:0]         range_count,
	output logic                               out_valid,
	input  logic                               out_stall,
	output prag_pkg::offset_t                  offset,
	output logic                               valid_res
);
	import prag_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CMP  = 3'd1;
	localparam logic [2:0] S_ADV  = 3'd2;
	localparam logic [2:0] S_MULB = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_MULP = 3'd5;
	localparam logic [2:0] S_FILL = 3'd6;

	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(UB_W - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(UC_W - 1);

	logic [2:0]            state_q;
	logic [UB_W-1:0]       unit_bytes_q;
	logic [UC_W-1:0]       unit_count_q;
	offset_t               cursor_q [MAX_RANGES];
	offset_t               end_q    [MAX_RANGES];

	mode_t                 op_q;
	logic [RANGE_W-1:0]    idx_q;
	logic [RANGE_W-1:0]    i_q;
	logic [RANGE_W-1:0]    last_q;
	logic [CNT_W-1:0]      n_q;
	logic [CNT_W-1:0]      step_q;
	logic                  ok_q;
	offset_t               acc_q;
	offset_t               mcand_q;
	logic [UB_W-1:0]       mplier_q;
	logic [UC_W-1:0]       div_q;
	logic [RANGE_W-1:0]    rem_q;
	offset_t               per_q;
	offset_t               buf_q;
	offset_t               pos_q;

	logic                  out_valid_q;
	offset_t               offset_q;
	logic                  valid_res_q;

	offset_t               alu_a;
	offset_t               alu_b;
	logic                  alu_sub;
	logic [OFFSET_W:0]     alu_sum;
	offset_t               acc_next;
	logic [RANGE_W:0]      trial;
	logic                  ge;
	logic [CNT_W-1:0]      n_clamp;
	logic                  in_acc;
	logic                  out_free;
	logic                  fill_done;
	logic [RANGE_W-1:0]    wr_idx;
	offset_t               cur_rd;
	offset_t               end_rd;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign offset    = offset_q;
	assign valid_res = valid_res_q;
	assign out_free  = !out_valid_q || !out_stall;

	assign cur_rd    = cursor_q[idx_q];
	assign end_rd    = end_q[idx_q];
	assign trial     = {rem_q, div_q[UC_W-1]};
	assign ge        = alu_sum[OFFSET_W];
	assign acc_next  = mplier_q[0] ? alu_sum[OFFSET_W-1:0] : acc_q;
	assign n_clamp   = (range_count > CNT_W'(MAX_RANGES)) ? CNT_W'(MAX_RANGES) : range_count;
	assign fill_done = (op_q == MODE_REWIND_ONE) || (i_q == last_q);
	assign wr_idx    = (op_q == MODE_REWIND_ONE) ? idx_q : i_q;

	always_comb begin
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		unique case (state_q) inside
			S_CMP: begin
				alu_a   = cur_rd;
				alu_b   = end_rd;
				alu_sub = 1'b1;
			end
			S_ADV: begin
				alu_a = cur_rd;
				alu_b = OFFSET_W'(unit_bytes_q);
			end
			S_MULB, S_MULP: begin
				alu_a = acc_q;
				alu_b = mcand_q;
			end
			S_DIV: begin
				alu_a   = OFFSET_W'(trial);
				alu_b   = OFFSET_W'(n_q);
				alu_sub = 1'b1;
			end
			S_FILL: begin
				alu_a = pos_q;
				alu_b = per_q;
			end
			default: begin
				alu_a = '0;
			end
		endcase
		alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
			+ (OFFSET_W+1)'(alu_sub);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_bytes_q <= UB_W'(16);
			unit_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_UNIT_BYTES) begin
				unit_bytes_q <= cfg_data[UB_W-1:0];
			end else if (cfg_index == REG_UNIT_COUNT) begin
				unit_count_q <= cfg_data[UC_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_RANGES; k++) begin
				cursor_q[k] <= '0;
				end_q[k]    <= '0;
			end
		end else if (state_q == S_ADV) begin
			if (out_free && ok_q) begin
				cursor_q[idx_q] <= alu_sum[OFFSET_W-1:0];
			end
		end else if (state_q == S_FILL) begin
			cursor_q[wr_idx] <= (op_q == MODE_EVEN_OUT) ? pos_q : '0;
			end_q[wr_idx]    <= (op_q == MODE_EVEN_OUT && i_q != last_q)
				? alu_sum[OFFSET_W-1:0] : buf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= MODE_NEXT;
			idx_q       <= '0;
			i_q         <= '0;
			last_q      <= '0;
			n_q         <= '0;
			step_q      <= '0;
			ok_q        <= 1'b0;
			acc_q       <= '0;
			mcand_q     <= '0;
			mplier_q    <= '0;
			div_q       <= '0;
			rem_q       <= '0;
			per_q       <= '0;
			buf_q       <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			offset_q    <= '0;
			valid_res_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_ADV) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						op_q     <= mode;
						idx_q    <= range_index[RANGE_W-1:0];
						acc_q    <= '0;
						mcand_q  <= OFFSET_W'(unit_count_q);
						mplier_q <= unit_bytes_q;
						step_q   <= '0;
						unique case (mode)
							MODE_NEXT: begin
								state_q <= S_CMP;
							end
							MODE_REWIND_ONE, MODE_REWIND_ALL: begin
								last_q  <= RANGE_W'(MAX_RANGES - 1);
								state_q <= S_MULB;
							end
							default: begin
								n_q    <= n_clamp;
								last_q <= RANGE_W'(n_clamp - CNT_W'(1));
								if (range_count != '0) begin
									state_q <= S_MULB;
								end
							end
						endcase
					end
				end
				S_CMP: begin
					ok_q    <= !ge;
					state_q <= S_ADV;
				end
				S_ADV: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						offset_q    <= ok_q ? cur_rd : '0;
						valid_res_q <= ok_q;
						state_q     <= S_IDLE;
					end
				end
				S_MULB, S_MULP: begin
					acc_q    <= acc_next;
					mcand_q  <= {mcand_q[OFFSET_W-2:0], 1'b0};
					mplier_q <= mplier_q >> 1;
					if (step_q == MUL_LAST) begin
						i_q    <= '0;
						pos_q  <= '0;
						step_q <= '0;
						if (state_q == S_MULP) begin
							per_q   <= acc_next;
							state_q <= S_FILL;
						end else begin
							buf_q <= acc_next;
							div_q <= unit_count_q;
							rem_q <= '0;
							state_q <= (op_q == MODE_EVEN_OUT) ? S_DIV : S_FILL;
						end
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_DIV: begin
					rem_q  <= ge ? alu_sum[RANGE_W-1:0] : trial[RANGE_W-1:0];
					div_q  <= {div_q[UC_W-2:0], ge};
					if (step_q == DIV_LAST) begin
						acc_q    <= '0;
						mcand_q  <= OFFSET_W'({div_q[UC_W-2:0], ge});
						mplier_q <= unit_bytes_q;
						step_q   <= '0;
						state_q  <= S_MULP;
					end else begin
						step_q <= step_q + CNT_W'(1);
					end
				end
				S_FILL: begin
					pos_q <= alu_sum[OFFSET_W-1:0];
					if (fill_done) begin
						state_q <= S_IDLE;
					end else begin
						i_q <= i_q + RANGE_W'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !valid_res |-> offset == '0)
		else $error("exhausted beat carries a nonzero offset");

	a_next_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && mode == MODE_NEXT |=> state_q == S_CMP)
		else $error("next beat did not start the compare step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> ({1'b0, rem_q} < n_q))
		else $error("divide remainder not below divisor");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FILL |-> i_q <= last_q)
		else $error("fill index ran past the last range");

	a_result_only_from_adv: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q ##1 out_valid_q |-> $past(state_q) == S_ADV)
		else $error("result raised outside the advance step");

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import prag_pkg::*;

	localparam int LIMIT  = 400000;
	localparam int SETTLE = 64;

	typedef struct packed {
		offset_t offset;
		logic    valid_res;
	} offset_beat_t;

	class range_tracker;
		int unsigned  unit_bytes;
		int unsigned  unit_count;
		logic [23:0]  cursor[MAX_RANGES];
		logic [23:0]  limit_off[MAX_RANGES];
		offset_beat_t pending_offsets[$];
		int           errors;
		int           shown;
		int           requests;
		int           results;
		int           nulls;

		function new();
			unit_bytes = 16;
			unit_count = 0;
			foreach (cursor[i]) begin
				cursor[i]    = '0;
				limit_off[i] = '0;
			end
		endfunction

		function void write_reg(cfg_idx_t idx, logic [15:0] data);
			if (idx == REG_UNIT_BYTES)
				unit_bytes = data[7:0];
			else if (idx == REG_UNIT_COUNT)
				unit_count = data;
		endfunction

		function logic [23:0] buffer_bytes();
			return 24'(unit_bytes * unit_count);
		endfunction

		function void rewind(int i);
			cursor[i]    = '0;
			limit_off[i] = buffer_bytes();
		endfunction

		function void accept_request(mode_t m, logic [2:0] idx, logic [3:0] cnt);
			offset_beat_t b;
			int unsigned  n;
			logic [23:0]  per;
			logic [23:0]  pos;
			requests++;
			case (m)
				MODE_NEXT: begin
					b.offset    = '0;
					b.valid_res = 1'b0;
					if (cursor[idx] < limit_off[idx]) begin
						b.offset    = cursor[idx];
						b.valid_res = 1'b1;
						cursor[idx] = cursor[idx] + 24'(unit_bytes);
					end
					pending_offsets.push_back(b);
				end
				MODE_REWIND_ONE: rewind(idx);
				MODE_REWIND_ALL: for (int i = 0; i < MAX_RANGES; i++) rewind(i);
				default: begin
					if (cnt != 0) begin
						n   = (cnt > MAX_RANGES) ? MAX_RANGES : cnt;
						per = 24'((unit_count / n) * unit_bytes);
						pos = '0;
						for (int i = 0; i < n; i++) begin
							cursor[i]    = pos;
							pos          = pos + per;
							limit_off[i] = pos;
						end
						limit_off[n-1] = buffer_bytes();
					end
				end
			endcase
		endfunction

		function void report(string msg);
			errors++;
			if (shown < 40) begin
				$display("[%0t] mismatch: %s", $time, msg);
				shown++;
			end
		endfunction

		function void check_offset(offset_t off, logic vr);
			offset_beat_t e;
			results++;
			if (pending_offsets.size() == 0) begin
				report($sformatf("unexpected beat offset=%h valid_res=%b", off, vr));
				return;
			end
			e = pending_offsets.pop_front();
			if (!vr)
				nulls++;
			if (vr !== e.valid_res)
				report($sformatf("valid_res %b, expected %b", vr, e.valid_res));
			if (off !== e.offset)
				report($sformatf("offset %h, expected %h", off, e.offset));
		endfunction
	endclass

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_valid   = 1'b0;
	logic                  cfg_ready;
	cfg_idx_t              cfg_index   = REG_UNIT_BYTES;
	logic [CFG_DATA_W-1:0] cfg_data    = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	mode_t                 mode        = MODE_NEXT;
	logic [2:0]            range_index = '0;
	logic [CNT_W-1:0]      range_count = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	offset_t               offset;
	logic                  valid_res;

	bit           calm        = 1'b0;
	int unsigned  cycle_count = 0;
	int           settings    = 0;
	range_tracker tracker     = new();

	partitioned_range_address_generator_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.range_index (range_index),
		.range_count (range_count),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.offset      (offset),
		.valid_res   (valid_res)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= LIMIT);
		$display("timeout after %0d cycles", cycle_count);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				tracker.check_offset(offset, valid_res);
			out_stall <= !calm && ($urandom_range(99) < 27);
		end
	end

	task automatic send_item(mode_t m, logic [2:0] idx, logic [3:0] cnt);
		if (!calm) begin
			while ($urandom_range(99) < 27) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid    <= 1'b1;
		mode        <= m;
		range_index <= idx;
		range_count <= cnt;
		do @(posedge clk); while (in_stall);
		tracker.accept_request(m, idx, cnt);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (tracker.pending_offsets.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [15:0] ub_data, logic [15:0] uc_data, bit swap);
		cfg_idx_t    idx;
		logic [15:0] data;
		for (int k = 0; k < 2; k++) begin
			idx  = ((k == 0) ^ swap) ? REG_UNIT_BYTES : REG_UNIT_COUNT;
			data = (idx == REG_UNIT_BYTES) ? ub_data : uc_data;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= data;
			do @(posedge clk); while (!cfg_ready);
			tracker.write_reg(idx, data);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	task automatic random_item();
		int unsigned r;
		r = $urandom_range(99);
		if ($urandom_range(4) == 0)
			send_item(mode_t'($urandom), 3'($urandom), 4'($urandom));
		else if (r < 72)
			send_item(MODE_NEXT, 3'($urandom), 4'($urandom));
		else if (r < 80)
			send_item(MODE_REWIND_ONE, 3'($urandom), 4'($urandom));
		else if (r < 86)
			send_item(MODE_REWIND_ALL, 3'($urandom), 4'($urandom));
		else
			send_item(MODE_EVEN_OUT, 3'($urandom),
				($urandom_range(5) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8)));
	endtask

	initial begin
		int unsigned ub;
		int unsigned uc;
		logic [7:0]  hi;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(MODE_NEXT, 3'd0, 4'd0);
		settle();
		write_regs(16'd255, 16'hffff, 1'b0);
		send_item(MODE_REWIND_ALL, 3'd0, 4'd0);
		send_item(MODE_NEXT, 3'd7, 4'd0);
		send_item(MODE_NEXT, 3'd7, 4'd0);
		send_item(MODE_EVEN_OUT, 3'd0, 4'd0);
		send_item(MODE_NEXT, 3'd0, 4'd0);
		send_item(MODE_EVEN_OUT, 3'd0, 4'd15);
		send_item(MODE_NEXT, 3'd7, 4'd0);
		send_item(MODE_NEXT, 3'd0, 4'd0);
		send_item(MODE_EVEN_OUT, 3'd0, 4'd3);
		send_item(MODE_NEXT, 3'd2, 4'd0);
		send_item(MODE_NEXT, 3'd5, 4'd0);
		send_item(MODE_REWIND_ONE, 3'd3, 4'd0);
		send_item(MODE_NEXT, 3'd3, 4'd0);
		settle();
		// upper byte of the unit size write must be dropped, leaving zero
		write_regs(16'hff00, 16'hffff, 1'b1);
		send_item(MODE_NEXT, 3'd4, 4'd0);
		send_item(MODE_NEXT, 3'd4, 4'd0);
		send_item(MODE_REWIND_ALL, 3'd0, 4'd0);
		send_item(MODE_NEXT, 3'd1, 4'd0);
		settle();
		write_regs(16'd1, 16'd3, 1'b0);
		send_item(MODE_REWIND_ONE, 3'd6, 4'd0);
		repeat (4) send_item(MODE_NEXT, 3'd6, 4'd0);
		send_item(MODE_EVEN_OUT, 3'd0, 4'd8);
		send_item(MODE_NEXT, 3'd7, 4'd0);

		for (int ph = 0; ph < 10; ph++) begin
			settle();
			case (ph)
				0: begin ub = 1;   uc = 0;     end
				1: begin ub = 255; uc = 65535; end
				2: begin ub = 255; uc = 1;     end
				3: begin ub = 1;   uc = 65535; end
				default: begin
					ub = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 255);
					uc = ($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(48);
				end
			endcase
			hi   = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
			calm = (ph == 5);
			write_regs({hi, 8'(ub)}, 16'(uc), 1'($urandom));
			if ($urandom_range(1))
				send_item(MODE_REWIND_ALL, 3'($urandom), 4'($urandom));
			else
				send_item(MODE_EVEN_OUT, 3'($urandom), 4'($urandom_range(1, 8)));
			repeat (79) random_item();
		end
		calm = 1'b0;
		settle();

		if (tracker.pending_offsets.size() != 0)
			tracker.report($sformatf("%0d offsets never arrived", tracker.pending_offsets.size()));
		$display("Ran %0d request beats across %0d register settings.",
			tracker.requests, settings);
		$display("Checked %0d offset beats, %0d of them on exhausted ranges.",
			tracker.results, tracker.nulls);
		if (tracker.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
